[design/follow_distance_speed_ramp_macros.svh]
// assertion helpers for the follow distance speed ramp
`ifndef FOLLOW_DISTANCE_SPEED_RAMP_MACROS_SVH
`define FOLLOW_DISTANCE_SPEED_RAMP_MACROS_SVH

// checked on clk_i, suspended while in reset
`define FDSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on clk_i at every edge, reset included
`define FDSR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[design/fdsr_pkg.sv]
package fdsr_pkg;

  localparam int unsigned SpeedW    = 11;
  localparam int unsigned DistW     = 13;
  localparam int unsigned GapW      = 12;
  localparam int unsigned GapSW     = 15;
  localparam int unsigned ProdW     = 23;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 13;

  localparam logic [SpeedW-1:0] SpeedFull = 11'd1024;

  localparam logic [1:0] OpTick  = 2'd0;
  localparam logic [1:0] OpStart = 2'd1;
  localparam logic [1:0] OpStop  = 2'd2;

  localparam logic [CfgIdxW-1:0] RegVehicleLen = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCritGap    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegStopGap    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegStartGap   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegFullGap    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegMinSpeed   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegSpeedStep  = 3'd6;

  typedef struct packed {
    logic [GapW-1:0]   vehicle_length_mm;
    logic [GapW-1:0]   critical_gap_mm;
    logic [GapW-1:0]   stop_gap_mm;
    logic [GapW-1:0]   start_gap_mm;
    logic [DistW-1:0]  full_gap_mm;
    logic [SpeedW-1:0] min_speed;
    logic [SpeedW-1:0] speed_step;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [ProdW-1:0] dividend;
    logic [DistW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [ProdW-1:0] quot;
  } div_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PREP  = 5'b00010,
    ST_MUL   = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_APPLY = 5'b10000
  } state_e;

endpackage

[design/follow_distance_speed_ramp.sv]
// speed ramp for a vehicle following a target
// input stream: one item per control tick or command; tuser carries the op
// (tick, start, stop), tdata the measured distance and the seen and motor
// failure flags. output stream: one result per input item with the drive
// command, the speed, the brake flag and the halt latch.
// configuration: write enable, register index and data, written while idle.
// sequence: a start, stop, unused op or a tick that needs no ramp goes
// through the prep and apply states; a tick on the linear ramp goes through
// prep, multiply, the 23-step restoring divider and apply.
// one item at a time: the next input transfer is taken once the result
// sits in the output register.
// reset: speed 0, brake off, halt latched until a start item, configuration
// back to its defaults.
// a stalled receiver holds the result in the output register; a new item
// can still be taken, but it waits before its result until the slot frees.
`include "follow_distance_speed_ramp_macros.svh"

module follow_distance_speed_ramp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fdsr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [fdsr_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // distance_mm[12:0], user_seen[13], fail_left[14], fail_right[15]
  input  logic [15:0]                    s_axis_tdata,
  // op[1:0]
  input  logic [1:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // motor_forward[0], speed_cmd[11:1], gyro_brake[12], halted[13], zero[15:14]
  output logic [15:0]                    m_axis_tdata
);

  localparam int unsigned SW = fdsr_pkg::SpeedW;
  localparam int unsigned GS = fdsr_pkg::GapSW;

  fdsr_pkg::cfg_t     cfg;
  fdsr_pkg::div_req_t div_req;
  fdsr_pkg::div_rsp_t div_rsp;
  fdsr_pkg::state_e   state_q, state_d;

  logic [1:0]                  op_q;
  logic [fdsr_pkg::DistW-1:0]  dist_q;
  logic                        seen_q, fail_q;
  logic                        crit_q, crit_d;
  logic                        neg_q, neg_d;
  logic [SW-1:0]               target_q, target_d;
  logic [SW-1:0]               lo_q, lo_d;
  logic [SW-1:0]               span_q, span_d;
  logic [fdsr_pkg::DistW-1:0]  absdiff_q, absdiff_d;
  logic [fdsr_pkg::DistW-1:0]  den_q, den_d;

  logic [SW-1:0] speed_q, speed_d;
  logic          halt_q, halt_d;
  logic          brake_q, brake_d;
  logic          mvalid_q, mvalid_d;
  logic [15:0]   mdata_q, mdata_d;

  logic signed [GS-1:0] gap, diff;
  logic [GS-1:0]        thr;
  logic                 tgt_zero, tgt_full;
  logic [SW-1:0]        slew, ramp_t;
  logic                 fwd;
  logic                 out_free;

  fdsr_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  fdsr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign s_axis_tready = (state_q == fdsr_pkg::ST_IDLE);
  assign out_free      = !mvalid_q || m_axis_tready;

  assign gap  = $signed({2'b00, dist_q}) - $signed({3'b000, cfg.vehicle_length_mm});
  assign diff = gap - $signed({3'b000, cfg.stop_gap_mm});
  assign thr  = (speed_q != '0) ? {3'b000, cfg.stop_gap_mm} : {3'b000, cfg.start_gap_mm};
  assign tgt_zero = !seen_q || (gap < $signed(thr));
  assign tgt_full = (gap > $signed({2'b00, cfg.full_gap_mm}))
                 || (cfg.full_gap_mm <= {1'b0, cfg.stop_gap_mm});

  always_comb begin
    if (neg_q) begin
      ramp_t = (div_rsp.quot >= fdsr_pkg::ProdW'(lo_q)) ? '0
             : SW'(lo_q - div_rsp.quot[SW-1:0]);
    end else begin
      ramp_t = SW'(lo_q + div_rsp.quot[SW-1:0]);
    end
  end

  always_comb begin
    if (target_q > speed_q) begin
      slew = ((target_q - speed_q) > cfg.speed_step) ? SW'(speed_q + cfg.speed_step)
                                                      : target_q;
    end else if (target_q < speed_q) begin
      slew = ((speed_q - target_q) > cfg.speed_step) ? SW'(speed_q - cfg.speed_step)
                                                      : target_q;
    end else begin
      slew = target_q;
    end
  end

  always_comb begin
    state_d   = state_q;
    crit_d    = crit_q;
    neg_d     = neg_q;
    target_d  = target_q;
    lo_d      = lo_q;
    span_d    = span_q;
    absdiff_d = absdiff_q;
    den_d     = den_q;
    speed_d   = speed_q;
    halt_d    = halt_q;
    brake_d   = brake_q;
    fwd       = 1'b0;
    mdata_d   = mdata_q;
    mvalid_d  = mvalid_q && !m_axis_tready;
    div_req.start    = 1'b0;
    div_req.dividend = fdsr_pkg::ProdW'(absdiff_q) * fdsr_pkg::ProdW'(span_q);
    div_req.divisor  = den_q;

    unique case (state_q)
      fdsr_pkg::ST_IDLE: begin
        if (s_axis_tvalid) state_d = fdsr_pkg::ST_PREP;
      end
      fdsr_pkg::ST_PREP: begin
        crit_d    = (gap <= $signed({3'b000, cfg.critical_gap_mm}));
        neg_d     = diff[GS-1];
        absdiff_d = diff[GS-1] ? fdsr_pkg::DistW'(-diff) : diff[fdsr_pkg::DistW-1:0];
        lo_d      = (cfg.min_speed > fdsr_pkg::SpeedFull) ? fdsr_pkg::SpeedFull
                                                          : cfg.min_speed;
        span_d    = fdsr_pkg::SpeedFull - lo_d;
        den_d     = cfg.full_gap_mm - {1'b0, cfg.stop_gap_mm};
        target_d  = tgt_zero ? '0 : fdsr_pkg::SpeedFull;
        if (op_q == fdsr_pkg::OpTick && !halt_q && !crit_d && !tgt_zero && !tgt_full) begin
          state_d = fdsr_pkg::ST_MUL;
        end else begin
          state_d = fdsr_pkg::ST_APPLY;
        end
      end
      fdsr_pkg::ST_MUL: begin
        state_d = fdsr_pkg::ST_DIV;
      end
      fdsr_pkg::ST_DIV: begin
        div_req.start = 1'b0;
        if (div_rsp.done) begin
          target_d = ramp_t;
          state_d  = fdsr_pkg::ST_APPLY;
        end
      end
      fdsr_pkg::ST_APPLY: begin
        if (out_free) begin
          case (op_q)
            fdsr_pkg::OpTick: begin
              if (!halt_q) begin
                speed_d = crit_q ? '0 : slew;
                if (fail_q) begin
                  speed_d = '0;
                  brake_d = 1'b1;
                  halt_d  = 1'b1;
                end else begin
                  fwd = 1'b1;
                end
              end
            end
            fdsr_pkg::OpStart: begin
              brake_d = 1'b0;
              halt_d  = 1'b0;
            end
            fdsr_pkg::OpStop: begin
              speed_d = '0;
              brake_d = 1'b0;
              halt_d  = 1'b1;
            end
            default: ;
          endcase
          mdata_d  = {2'b00, halt_d, brake_d, speed_d, fwd};
          mvalid_d = 1'b1;
          state_d  = fdsr_pkg::ST_IDLE;
        end
      end
      default: state_d = fdsr_pkg::ST_IDLE;
    endcase

    if (state_q == fdsr_pkg::ST_MUL) div_req.start = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= fdsr_pkg::ST_IDLE;
      speed_q  <= '0;
      halt_q   <= 1'b1;
      brake_q  <= 1'b0;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      speed_q  <= speed_d;
      halt_q   <= halt_d;
      brake_q  <= brake_d;
      mvalid_q <= mvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op_q   <= s_axis_tuser;
      dist_q <= s_axis_tdata[12:0];
      seen_q <= s_axis_tdata[13];
      fail_q <= s_axis_tdata[14] | s_axis_tdata[15];
    end
    crit_q    <= crit_d;
    neg_q     <= neg_d;
    target_q  <= target_d;
    lo_q      <= lo_d;
    span_q    <= span_d;
    absdiff_q <= absdiff_d;
    den_q     <= den_d;
    mdata_q   <= mdata_d;
  end

  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = mdata_q;

  `FDSR_ASSERT(a_one_at_a_time, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "item overlap")
  `FDSR_ASSERT(a_speed_range, m_axis_tvalid |-> m_axis_tdata[11:1] <= fdsr_pkg::SpeedFull, "speed over full")
  `FDSR_ASSERT(a_halt_no_fwd, m_axis_tvalid && m_axis_tdata[13] |-> !m_axis_tdata[0], "forward while halted")
  `FDSR_ASSERT_ALWAYS(a_brake_halt, brake_q |-> halt_q, "brake without halt")

endmodule

[design/fdsr_cfg.sv]
module fdsr_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           we_i,
  input  logic [fdsr_pkg::CfgIdxW-1:0]   idx_i,
  input  logic [fdsr_pkg::CfgDataW-1:0]  data_i,
  output fdsr_pkg::cfg_t                 cfg_o
);

  fdsr_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (idx_i)
        fdsr_pkg::RegVehicleLen: cfg_d.vehicle_length_mm = data_i[11:0];
        fdsr_pkg::RegCritGap:    cfg_d.critical_gap_mm   = data_i[11:0];
        fdsr_pkg::RegStopGap:    cfg_d.stop_gap_mm       = data_i[11:0];
        fdsr_pkg::RegStartGap:   cfg_d.start_gap_mm      = data_i[11:0];
        fdsr_pkg::RegFullGap:    cfg_d.full_gap_mm       = data_i;
        fdsr_pkg::RegMinSpeed:   cfg_d.min_speed         = data_i[10:0];
        fdsr_pkg::RegSpeedStep:  cfg_d.speed_step        = data_i[10:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vehicle_length_mm <= 12'd0;
      cfg_q.critical_gap_mm   <= 12'd100;
      cfg_q.stop_gap_mm       <= 12'd300;
      cfg_q.start_gap_mm      <= 12'd700;
      cfg_q.full_gap_mm       <= 13'd1700;
      cfg_q.min_speed         <= 11'd358;
      cfg_q.speed_step        <= 11'd51;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[design/fdsr_div.sv]
module fdsr_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fdsr_pkg::div_req_t  req_i,
  output fdsr_pkg::div_rsp_t  rsp_o
);

  localparam int unsigned CntW = $clog2(fdsr_pkg::ProdW + 1);
  localparam logic [CntW-1:0] Steps = CntW'(fdsr_pkg::ProdW);

  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [CntW-1:0]              cnt_q, cnt_d;
  logic [fdsr_pkg::ProdW-1:0]   dvd_q, dvd_d;
  logic [fdsr_pkg::DistW-1:0]   dvs_q, dvs_d;
  logic [fdsr_pkg::DistW-1:0]   rem_q, rem_d;
  logic [fdsr_pkg::DistW:0]     rem_sh;
  logic                         qbit;

  always_comb begin
    rem_sh = {rem_q, dvd_q[fdsr_pkg::ProdW-1]};
    qbit   = (rem_sh >= {1'b0, dvs_q});
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = Steps;
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = qbit ? fdsr_pkg::DistW'(rem_sh - {1'b0, dvs_q})
                   : rem_sh[fdsr_pkg::DistW-1:0];
      dvd_d = {dvd_q[fdsr_pkg::ProdW-2:0], qbit};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = dvd_q;

endmodule

[tb/tb_follow_distance_speed_ramp.sv]
`timescale 1ns / 1ps

module tb_follow_distance_speed_ramp;
  import fdsr_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned IDLE_LIMIT = 3000;
  localparam int unsigned PHASES = 8;
  localparam int unsigned ITEMS_PER_PHASE = 116;
  localparam int unsigned HOLD_CYCLES = 240;

  // packed so that it lines up with m_axis_tdata[13:0]
  typedef struct packed {
    logic              halted;
    logic              brake;
    logic [SpeedW-1:0] speed;
    logic              forward;
  } ramp_out_t;

  typedef struct {
    logic [1:0]       op;
    logic [DistW-1:0] dist_mm;
    logic             seen;
    logic             fail_l;
    logic             fail_r;
    bit               typed;
    ramp_out_t        res;
  } tick_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [15:0]         s_axis_tdata = '0;
  logic [1:0]          s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [15:0]         m_axis_tdata;

  // predictor state
  cfg_t              ramp_cfg;
  logic [SpeedW-1:0] cur_speed;
  logic              halt_on;
  logic              brake_on;

  ramp_out_t   results_due[$];
  tick_row_t   tick_table[$];
  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned idle_cnt = 0;
  bit          no_idle = 1'b0;
  bit          hold_req = 1'b0;

  follow_distance_speed_ramp dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic longint ramp_target(longint gap, logic seen);
    longint thr, full, stop, lo, span, den, diff, term, t;
    full = longint'(ramp_cfg.full_gap_mm);
    stop = longint'(ramp_cfg.stop_gap_mm);
    thr = (cur_speed != '0) ? stop : longint'(ramp_cfg.start_gap_mm);
    if (!seen || gap < thr) return 0;
    if (gap > full || full <= stop) return longint'(SpeedFull);
    lo = longint'(ramp_cfg.min_speed);
    if (lo > longint'(SpeedFull)) lo = longint'(SpeedFull);
    span = longint'(SpeedFull) - lo;
    den = full - stop;
    diff = gap - stop;
    if (diff >= 0) term = (diff * span) / den;
    else term = -(((-diff) * span) / den);
    t = lo + term;
    if (t < 0) t = 0;
    if (t > longint'(SpeedFull)) t = longint'(SpeedFull);
    return t;
  endfunction

  function automatic ramp_out_t apply_item(logic [1:0] op, logic [DistW-1:0] dist_mm,
                                           logic seen, logic fail);
    ramp_out_t r;
    longint gap, cur, step, t, nxt;
    r.forward = 1'b0;
    if (op == OpTick) begin
      if (!halt_on) begin
        gap = longint'(dist_mm) - longint'(ramp_cfg.vehicle_length_mm);
        if (gap <= longint'(ramp_cfg.critical_gap_mm)) begin
          cur_speed = '0;
        end else begin
          cur = longint'(cur_speed);
          step = longint'(ramp_cfg.speed_step);
          t = ramp_target(gap, seen);
          if (t > cur) begin
            nxt = cur + step;
            if (nxt > t) nxt = t;
          end else if (t < cur) begin
            nxt = cur - step;
            if (nxt < t) nxt = t;
          end else begin
            nxt = t;
          end
          cur_speed = nxt[SpeedW-1:0];
        end
        if (fail) begin
          cur_speed = '0;
          brake_on = 1'b1;
          halt_on = 1'b1;
        end else begin
          r.forward = 1'b1;
        end
      end
    end else if (op == OpStart) begin
      brake_on = 1'b0;
      halt_on = 1'b0;
    end else if (op == OpStop) begin
      cur_speed = '0;
      brake_on = 1'b0;
      halt_on = 1'b1;
    end
    r.speed = cur_speed;
    r.brake = brake_on;
    r.halted = halt_on;
    return r;
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [DistW-1:0] dist_mm,
                           input logic seen, input logic fail_l, input logic fail_r,
                           input bit typed, input ramp_out_t typed_res);
    ramp_out_t r;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {fail_r, fail_l, seen, dist_mm};
    do @(posedge clk_i); while (!s_axis_tready);
    r = apply_item(op, dist_mm, seen, fail_l | fail_r);
    results_due.push_back(typed ? typed_res : r);
    items_sent++;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      RegVehicleLen: ramp_cfg.vehicle_length_mm = data[GapW-1:0];
      RegCritGap:    ramp_cfg.critical_gap_mm = data[GapW-1:0];
      RegStopGap:    ramp_cfg.stop_gap_mm = data[GapW-1:0];
      RegStartGap:   ramp_cfg.start_gap_mm = data[GapW-1:0];
      RegFullGap:    ramp_cfg.full_gap_mm = data[DistW-1:0];
      RegMinSpeed:   ramp_cfg.min_speed = data[SpeedW-1:0];
      RegSpeedStep:  ramp_cfg.speed_step = data[SpeedW-1:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input cfg_t c);
    cfg_write(RegVehicleLen, CfgDataW'(c.vehicle_length_mm));
    cfg_write(RegCritGap, CfgDataW'(c.critical_gap_mm));
    cfg_write(RegStopGap, CfgDataW'(c.stop_gap_mm));
    cfg_write(RegStartGap, CfgDataW'(c.start_gap_mm));
    cfg_write(RegFullGap, CfgDataW'(c.full_gap_mm));
    cfg_write(RegMinSpeed, CfgDataW'(c.min_speed));
    cfg_write(RegSpeedStep, CfgDataW'(c.speed_step));
    cfg_we_i <= 1'b0;
  endtask

  function automatic cfg_t phase_settings(int unsigned ph);
    cfg_t c;
    case (ph)
      0: c = '{12'd0, 12'd100, 12'd300, 12'd700, 13'd1700, 11'd358, 11'd51};
      1: c = '{12'd4095, 12'd4095, 12'd4095, 12'd4095, 13'd8191, 11'd2047, 11'd2047};
      2: c = '{12'd0, 12'd0, 12'd0, 12'd0, 13'd0, 11'd0, 11'd0};
      3: c = '{12'd50, 12'd20, 12'd900, 12'd1200, 13'd600, 11'd200, 11'd300};
      4: c = '{12'd200, 12'd50, 12'd250, 12'd400, 13'd1000, 11'd1500, 11'd7};
      7: c = '{12'd1000, 12'd1, 12'd2, 12'd3, 13'd4, 11'd0, 11'd1024};
      default: begin
        c.vehicle_length_mm = GapW'($urandom_range(0, 600));
        c.critical_gap_mm = GapW'($urandom_range(0, 400));
        c.stop_gap_mm = GapW'($urandom_range(0, 1500));
        c.start_gap_mm = GapW'($urandom_range(0, 2500));
        c.full_gap_mm = DistW'($urandom_range(0, 5000));
        c.min_speed = SpeedW'($urandom_range(0, 1100));
        c.speed_step = SpeedW'($urandom_range(1, 400));
      end
    endcase
    return c;
  endfunction

  // distances cluster around the thresholds as seen through the vehicle length, or are spread at random
  function automatic logic [DistW-1:0] pick_distance();
    int base, d, hi;
    case ($urandom_range(0, 9))
      0: base = int'(ramp_cfg.critical_gap_mm);
      1: base = int'(ramp_cfg.stop_gap_mm);
      2: base = int'(ramp_cfg.start_gap_mm);
      3: base = int'(ramp_cfg.full_gap_mm);
      4, 5, 6: begin
        hi = int'(ramp_cfg.vehicle_length_mm) + int'(ramp_cfg.full_gap_mm) + 300;
        if (hi > 8191) hi = 8191;
        return DistW'($urandom_range(0, hi));
      end
      default: return DistW'($urandom_range(0, 8191));
    endcase
    d = base + int'(ramp_cfg.vehicle_length_mm) + int'($urandom_range(0, 6)) - 3;
    if (d < 0) d = 0;
    if (d > 8191) d = 8191;
    return d[DistW-1:0];
  endfunction

  task automatic add_row(input logic [1:0] op, input int dist_mm, input logic seen,
                         input logic fail_l, input logic fail_r, input bit typed,
                         input logic fwd, input int spd, input logic brk, input logic hlt);
    tick_row_t row;
    row.op = op;
    row.dist_mm = DistW'(dist_mm);
    row.seen = seen;
    row.fail_l = fail_l;
    row.fail_r = fail_r;
    row.typed = typed;
    row.res.forward = fwd;
    row.res.speed = SpeedW'(spd);
    row.res.brake = brk;
    row.res.halted = hlt;
    tick_table.push_back(row);
  endtask

  task automatic check_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
    end
  endtask

  // output transfer checker
  always @(posedge clk_i) begin
    ramp_out_t got, exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[13:0];
      results_seen++;
      if (results_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got %h", $time, m_axis_tdata);
      end else begin
        exp_r = results_due.pop_front();
        check_field("motor_forward", exp_r.forward, got.forward);
        check_field("speed_cmd", exp_r.speed, got.speed);
        check_field("gyro_brake", exp_r.brake, got.brake);
        check_field("halted", exp_r.halted, got.halted);
      end
    end
  end

  // receiver side: random stalls, one long hold-off on request
  initial begin
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [1:0] op;
    logic       fl, fr;
    ramp_out_t  none;
    int unsigned r;
    none = '0;
    ramp_cfg = phase_settings(0);
    cur_speed = '0;
    halt_on = 1'b1;
    brake_on = 1'b0;

    // halted at reset, then start, ramp, thresholds, failures, stop
    add_row(OpTick, 8191, 1, 1, 1, 1, 0, 0, 0, 1);
    add_row(OP_UNUSED, 8191, 1, 1, 1, 1, 0, 0, 0, 1);
    add_row(OpStop, 0, 0, 0, 0, 1, 0, 0, 0, 1);
    add_row(OpStart, 0, 0, 0, 0, 1, 0, 0, 0, 0);
    add_row(OpTick, 0, 1, 0, 0, 1, 1, 0, 0, 0);
    add_row(OpTick, 699, 1, 0, 0, 0, 0, 0, 0, 0);
    add_row(OpTick, 700, 1, 0, 0, 0, 0, 0, 0, 0);
    add_row(OpTick, 8191, 1, 0, 0, 0, 0, 0, 0, 0);
    add_row(OpTick, 8191, 0, 0, 0, 0, 0, 0, 0, 0);
    for (int i = 0; i < 4; i++) add_row(OpTick, 8191, 1, 0, 0, 0, 0, 0, 0, 0);
    add_row(OpTick, 300, 1, 0, 0, 0, 0, 0, 0, 0);
    add_row(OpTick, 299, 1, 0, 0, 0, 0, 0, 0, 0);
    add_row(OpTick, 1700, 1, 0, 0, 0, 0, 0, 0, 0);
    add_row(OpTick, 1701, 1, 0, 0, 0, 0, 0, 0, 0);
    add_row(OpTick, 101, 1, 0, 0, 0, 0, 0, 0, 0);
    add_row(OpTick, 100, 1, 0, 0, 1, 1, 0, 0, 0);
    add_row(OpTick, 8191, 1, 1, 0, 1, 0, 0, 1, 1);
    add_row(OpStart, 8191, 1, 1, 1, 1, 0, 0, 0, 0);
    add_row(OpTick, 8191, 1, 0, 1, 1, 0, 0, 1, 1);
    add_row(OpStart, 0, 0, 0, 0, 1, 0, 0, 0, 0);
    add_row(OpTick, 8191, 1, 0, 0, 0, 0, 0, 0, 0);
    add_row(OpStop, 8191, 1, 1, 1, 1, 0, 0, 0, 1);
    add_row(OP_UNUSED, 0, 0, 0, 0, 1, 0, 0, 0, 1);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (tick_table[i])
      send_item(tick_table[i].op, tick_table[i].dist_mm, tick_table[i].seen,
                tick_table[i].fail_l, tick_table[i].fail_r, tick_table[i].typed,
                tick_table[i].res);
    drain();

    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      if (ph == PHASES - 1) no_idle = 1'b1;
      load_settings(phase_settings(ph));
      @(posedge clk_i);
      if (ph == 1) hold_req = 1'b1;
      for (int unsigned k = 0; k < ITEMS_PER_PHASE; k++) begin
        r = $urandom_range(0, 99);
        if (halt_on && r < 60) op = OpStart;
        else if (r < 63) op = OpStop;
        else if (r < 65) op = OP_UNUSED;
        else if (r < 68) op = OpStart;
        else op = OpTick;
        fl = ($urandom_range(0, 39) == 0);
        fr = ($urandom_range(0, 39) == 0);
        send_item(op, pick_distance(), $urandom_range(0, 9) != 0, fl, fr, 1'b0, none);
      end
      drain();
    end

    repeat (40) @(posedge clk_i);
    $display("covered %0d items over %0d register settings, %0d results checked,",
             items_sent, PHASES, results_seen);
    $display("with random stalls on both sides and one long output hold-off");
    if (errors == 0 && results_due.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
